/* sv/esp3pd_pkg.sv */
// ----------------------------------------------------------------------------
// esp3pd_pkg
// Types, constants and the CRC8 step shared by the serial packet deframer.
// ----------------------------------------------------------------------------
package esp3pd_pkg;

	localparam int HDR_LEN   = 4;
	localparam int FRONT_LEN = 10;
	localparam int TAIL_LEN  = 7;

	localparam logic [7:0] SYNC_BYTE     = 8'h55;
	localparam logic [7:0] CRC_POLY      = 8'h07;
	localparam logic [7:0] TYPE_RADIO    = 8'h01;
	localparam logic [7:0] TYPE_RESPONSE = 8'h02;
	localparam logic [7:0] RET_CODE_OK   = 8'h00;
	localparam logic [7:0] ORG_RPS       = 8'hF6;
	localparam logic [7:0] ORG_1BS       = 8'hD5;
	localparam logic [7:0] ORG_4BS       = 8'hA5;

	localparam logic [1:0] RES_NEW     = 2'd0;
	localparam logic [1:0] RES_INVALID = 2'd1;
	localparam logic [1:0] RES_BAD_CRC = 2'd2;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HEADER,
		PH_HCRC,
		PH_DATA,
		PH_DCRC
	} phase_t;

	// End-of-packet event from the parser to the result stage
	typedef struct packed {
		logic                          fire;
		logic                          reject;
		logic [1:0]                    rej_code;
		logic [7:0]                    pkt_type;
		logic [FRONT_LEN-1:0][7:0]     front;
		logic [TAIL_LEN-2:0][7:0]      tail;
	} fin_t;

	// CRC8, poly 0x07, MSB first, no reflection
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

endpackage

/* sv/esp3pd_rx_if.sv */
// ----------------------------------------------------------------------------
// esp3pd_rx_if
// Serial byte channel into the deframer.
// ----------------------------------------------------------------------------
interface esp3pd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* sv/esp3pd_res_if.sv */
// ----------------------------------------------------------------------------
// esp3pd_res_if
// Decoded telegram channel out of the deframer.
// ----------------------------------------------------------------------------
interface esp3pd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_code;
	logic [7:0]  packet_kind;
	logic [7:0]  radio_org;
	logic [31:0] payload_word;
	logic [31:0] sender_id;
	logic [7:0]  sender_status;
	logic [7:0]  subtelegram_count;
	logic [31:0] destination_id;
	logic [7:0]  signal_dbm;
	logic [47:0] response_bytes;

	modport source (output valid, output result_code, output packet_kind, output radio_org,
		output payload_word, output sender_id, output sender_status,
		output subtelegram_count, output destination_id, output signal_dbm,
		output response_bytes, input ready);
	modport sink (input valid, input result_code, input packet_kind, input radio_org,
		input payload_word, input sender_id, input sender_status,
		input subtelegram_count, input destination_id, input signal_dbm,
		input response_bytes, output ready);
endinterface

/* sv/esp3_packet_deframer_unit.sv */
// Output: a result word is registered and appears in the cycle after the data
// CRC byte (or the rejecting header CRC byte) is accepted.
// Throughput: one byte per cycle unless a held word waits on a stalled sink;
// parser state and CRC8 update per byte, and a taken word frees the output.
// Reset: arst_n returns the block to sync hunt and empties the output register.
// ----------------------------------------------------------------------------
// esp3_packet_deframer_unit
// Serial packet deframer with header and data CRC8 checks and telegram decode.
// ----------------------------------------------------------------------------
module esp3_packet_deframer_unit (
	input logic          clk,
	input logic          arst_n,
	esp3pd_rx_if.sink    din,
	esp3pd_res_if.source dout
);

	esp3pd_pkg::fin_t fin;
	logic             busy;
	logic             take;

	assign din.ready = !busy;
	assign take      = din.valid && !busy;

	esp3pd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (din.rx_byte),
		.fin     (fin)
	);

	esp3pd_result u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.fin    (fin),
		.busy   (busy),
		.dout   (dout)
	);

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> dout.result_code != 2'd3)
		else $error("result code out of range");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.result_code != esp3pd_pkg::RES_NEW |->
			dout.sender_id == 32'h0 && dout.response_bytes == 48'h0 &&
			dout.radio_org == 8'h0)
		else $error("rejected word carries decoded fields");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!dout.valid |-> din.ready)
		else $error("input stalled with empty output register");

	a_result_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !$past(dout.valid) |-> $past(din.valid && din.ready))
		else $error("result word without an accepted byte");

endmodule

/* sv/esp3pd_parser.sv */
// ----------------------------------------------------------------------------
// esp3pd_parser
// Sync hunt, header and data capture, running CRC8 and packet end detection.
// ----------------------------------------------------------------------------
module esp3pd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	output esp3pd_pkg::fin_t  fin
);

	esp3pd_pkg::phase_t phase_q, phase_d;
	logic [16:0] pos_q, pos_d;
	logic [16:0] len_q, len_d;
	logic [7:0]  crc_q, crc_d;
	logic [esp3pd_pkg::HDR_LEN-1:0][7:0]   hdr_q, hdr_d;
	logic [esp3pd_pkg::FRONT_LEN-1:0][7:0] front_q, front_d;
	logic [esp3pd_pkg::TAIL_LEN-1:0][7:0]  tail_q, tail_d;
	logic [7:0]  crc_upd;
	logic [16:0] pos_inc;

	assign crc_upd = esp3pd_pkg::crc8_next(crc_q, rx_byte);
	assign pos_inc = pos_q + 17'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		crc_d   = crc_q;
		hdr_d   = hdr_q;
		front_d = front_q;
		tail_d  = tail_q;
		fin     = '0;
		fin.pkt_type = hdr_q[3];
		fin.front    = front_q;
		fin.tail     = tail_q[esp3pd_pkg::TAIL_LEN-2:0];
		if (take) begin
			case (phase_q)
				esp3pd_pkg::PH_HUNT: begin
					if (rx_byte == esp3pd_pkg::SYNC_BYTE) begin
						pos_d   = '0;
						len_d   = '0;
						crc_d   = '0;
						hdr_d   = '0;
						front_d = '0;
						tail_d  = '0;
						phase_d = esp3pd_pkg::PH_HEADER;
					end
				end
				esp3pd_pkg::PH_HEADER: begin
					hdr_d[pos_q[1:0]] = rx_byte;
					crc_d = crc_upd;
					pos_d = pos_inc;
					if (pos_inc >= 17'(esp3pd_pkg::HDR_LEN))
						phase_d = esp3pd_pkg::PH_HCRC;
				end
				esp3pd_pkg::PH_HCRC: begin
					if (hdr_q[0] == 8'h00 && hdr_q[1] == 8'h00 && hdr_q[2] == 8'h00) begin
						fin.fire     = 1'b1;
						fin.reject   = 1'b1;
						fin.rej_code = esp3pd_pkg::RES_INVALID;
						phase_d      = esp3pd_pkg::PH_HUNT;
					end else if (crc_q != rx_byte) begin
						fin.fire     = 1'b1;
						fin.reject   = 1'b1;
						fin.rej_code = esp3pd_pkg::RES_BAD_CRC;
						phase_d      = esp3pd_pkg::PH_HUNT;
					end else begin
						len_d   = {1'b0, hdr_q[0], 8'h00} + 17'(hdr_q[1]) + 17'(hdr_q[2]);
						pos_d   = '0;
						crc_d   = '0;
						phase_d = esp3pd_pkg::PH_DATA;
					end
				end
				esp3pd_pkg::PH_DATA: begin
					for (int i = 0; i < esp3pd_pkg::FRONT_LEN; i++) begin
						if (pos_q == 17'(i))
							front_d[i] = rx_byte;
					end
					tail_d = {rx_byte, tail_q[esp3pd_pkg::TAIL_LEN-1:1]};
					crc_d  = crc_upd;
					pos_d  = pos_inc;
					if (pos_inc >= len_q)
						phase_d = esp3pd_pkg::PH_DCRC;
				end
				esp3pd_pkg::PH_DCRC: begin
					fin.fire = 1'b1;
					if (crc_q != rx_byte) begin
						fin.reject   = 1'b1;
						fin.rej_code = esp3pd_pkg::RES_BAD_CRC;
					end
					phase_d = esp3pd_pkg::PH_HUNT;
				end
				default: phase_d = esp3pd_pkg::PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= esp3pd_pkg::PH_HUNT;
			pos_q   <= '0;
			len_q   <= '0;
			crc_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			crc_q   <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		hdr_q   <= hdr_d;
		front_q <= front_d;
		tail_q  <= tail_d;
	end

endmodule

/* sv/esp3pd_result.sv */
// ----------------------------------------------------------------------------
// esp3pd_result
// Field decode of a finished packet and the output register.
// ----------------------------------------------------------------------------
module esp3pd_result (
	input  logic             clk,
	input  logic             arst_n,
	input  esp3pd_pkg::fin_t fin,
	output logic             busy,
	esp3pd_res_if.source     dout
);

	logic        valid_q;
	logic [1:0]  code_d;
	logic [7:0]  org_d, status_d, sub_d, dbm_d;
	logic [31:0] pay_d, sid_d, dst_d;
	logic [47:0] resp_d;
	logic [1:0]  code_q;
	logic [7:0]  kind_q, org_q, status_q, sub_q, dbm_q;
	logic [31:0] pay_q, sid_q, dst_q;
	logic [47:0] resp_q;

	always_comb begin
		code_d   = esp3pd_pkg::RES_NEW;
		org_d    = '0;
		pay_d    = '0;
		sid_d    = '0;
		status_d = '0;
		sub_d    = '0;
		dst_d    = '0;
		dbm_d    = '0;
		resp_d   = '0;
		if (fin.reject) begin
			code_d = fin.rej_code;
		end else if (fin.pkt_type == esp3pd_pkg::TYPE_RESPONSE &&
			fin.front[0] != esp3pd_pkg::RET_CODE_OK) begin
			code_d = esp3pd_pkg::RES_INVALID;
		end else begin
			org_d = fin.front[0];
			if (fin.pkt_type == esp3pd_pkg::TYPE_RADIO) begin
				sub_d = fin.tail[0];
				dst_d = {fin.tail[4], fin.tail[3], fin.tail[2], fin.tail[1]};
				dbm_d = fin.tail[5];
				if (fin.front[0] == esp3pd_pkg::ORG_RPS || fin.front[0] == esp3pd_pkg::ORG_1BS) begin
					pay_d    = {24'h0, fin.front[1]};
					sid_d    = {fin.front[5], fin.front[4], fin.front[3], fin.front[2]};
					status_d = fin.front[6];
				end else if (fin.front[0] == esp3pd_pkg::ORG_4BS) begin
					pay_d    = {fin.front[1], fin.front[2], fin.front[3], fin.front[4]};
					sid_d    = {fin.front[8], fin.front[7], fin.front[6], fin.front[5]};
					status_d = fin.front[9];
				end
			end else if (fin.pkt_type == esp3pd_pkg::TYPE_RESPONSE) begin
				resp_d = {fin.front[5], fin.front[4], fin.front[3],
					fin.front[2], fin.front[1], fin.front[0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fin.fire) begin
			valid_q <= 1'b1;
		end else if (dout.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.fire) begin
			code_q   <= code_d;
			kind_q   <= fin.pkt_type;
			org_q    <= org_d;
			pay_q    <= pay_d;
			sid_q    <= sid_d;
			status_q <= status_d;
			sub_q    <= sub_d;
			dst_q    <= dst_d;
			dbm_q    <= dbm_d;
			resp_q   <= resp_d;
		end
	end

	// a held word blocks new input only while the sink stalls
	assign busy = valid_q && !dout.ready;

	assign dout.valid             = valid_q;
	assign dout.result_code       = code_q;
	assign dout.packet_kind       = kind_q;
	assign dout.radio_org         = org_q;
	assign dout.payload_word      = pay_q;
	assign dout.sender_id         = sid_q;
	assign dout.sender_status     = status_q;
	assign dout.subtelegram_count = sub_q;
	assign dout.destination_id    = dst_q;
	assign dout.signal_dbm        = dbm_q;
	assign dout.response_bytes    = resp_q;

endmodule

/* sim/tb_esp3_packet_deframer_unit.sv */
// ----------------------------------------------------------------------------
// tb_esp3_packet_deframer_unit
// Self-checking bench for the serial packet deframer. A table of directed
// packets (zero length, bad header and data CRC, rejected responses, short
// data, sync bytes inside a packet, a length of 256) is followed by random
// packet streams with noise and broken frames. Every accepted byte runs
// through a bit-true deframer predictor; every result word is compared field
// by field. Both channels idle at random, with long output holds.
// ----------------------------------------------------------------------------
module tb_esp3_packet_deframer_unit;

	localparam int KEEP_FRONT   = 10;
	localparam int KEEP_TAIL    = 7;
	localparam int TARGET_BYTES = 400;
	localparam int HOLD_CYCLES  = 100;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_TAIL   = 16;
	localparam int MAX_SHOWN    = 40;
	localparam int NUM_ROWS     = 23;

	localparam logic [1:0] FILL_RAND = 2'd0;
	localparam logic [1:0] FILL_ZERO = 2'd1;
	localparam logic [1:0] FILL_ONES = 2'd2;
	localparam logic [1:0] FILL_SYNC = 2'd3;

	typedef struct packed {
		logic [1:0]  code;
		logic [7:0]  kind;
		logic [7:0]  org;
		logic [31:0] payload;
		logic [31:0] sid;
		logic [7:0]  status;
		logic [7:0]  subcnt;
		logic [31:0] dest;
		logic [7:0]  dbm;
		logic [47:0] resp;
	} telegram_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic [1:0] code;
		logic [7:0] kind;
	} tx_byte_t;

	typedef struct packed {
		logic [7:0]  kind;
		logic [7:0]  org;
		logic [15:0] dlen;
		logic [7:0]  olen;
		logic        bad_h;
		logic        bad_d;
		logic [1:0]  fill;
		logic        typed;
		logic [1:0]  code;
	} pkt_row_t;

	// kind, first data byte, data length, option length, bad hcrc, bad dcrc,
	// fill, typed expectation, typed result code
	pkt_row_t dir_rows [NUM_ROWS] = '{
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_RPS, 16'd0, 8'd0, 1'b0, 1'b0, FILL_RAND,
			1'b1, esp3pd_pkg::RES_INVALID},
		'{8'hFF, 8'h00, 16'd0, 8'd0, 1'b1, 1'b0, FILL_RAND,
			1'b1, esp3pd_pkg::RES_INVALID},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_RPS, 16'd7, 8'd7, 1'b1, 1'b0, FILL_RAND,
			1'b1, esp3pd_pkg::RES_BAD_CRC},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_4BS, 16'd10, 8'd7, 1'b0, 1'b1, FILL_RAND,
			1'b1, esp3pd_pkg::RES_BAD_CRC},
		'{esp3pd_pkg::TYPE_RESPONSE, 8'h01, 16'd1, 8'd0, 1'b0, 1'b0, FILL_RAND,
			1'b1, esp3pd_pkg::RES_INVALID},
		'{esp3pd_pkg::TYPE_RESPONSE, 8'hFF, 16'd6, 8'd0, 1'b0, 1'b0, FILL_ONES,
			1'b1, esp3pd_pkg::RES_INVALID},
		'{esp3pd_pkg::TYPE_RESPONSE, esp3pd_pkg::RET_CODE_OK, 16'd1, 8'd0, 1'b0, 1'b0,
			FILL_RAND, 1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RESPONSE, esp3pd_pkg::RET_CODE_OK, 16'd6, 8'd0, 1'b0, 1'b0,
			FILL_ONES, 1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RESPONSE, esp3pd_pkg::RET_CODE_OK, 16'd12, 8'd3, 1'b0, 1'b0,
			FILL_RAND, 1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_RPS, 16'd7, 8'd7, 1'b0, 1'b0, FILL_RAND,
			1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_1BS, 16'd7, 8'd7, 1'b0, 1'b0, FILL_ONES,
			1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_4BS, 16'd10, 8'd7, 1'b0, 1'b0, FILL_ZERO,
			1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_4BS, 16'd10, 8'd0, 1'b0, 1'b0, FILL_RAND,
			1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_RPS, 16'd2, 8'd0, 1'b0, 1'b0, FILL_RAND,
			1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, 8'h00, 16'd7, 8'd7, 1'b0, 1'b0, FILL_RAND,
			1'b0, esp3pd_pkg::RES_NEW},
		'{8'h00, 8'hFF, 16'd5, 8'd0, 1'b0, 1'b0, FILL_RAND,
			1'b0, esp3pd_pkg::RES_NEW},
		'{8'hFF, 8'h00, 16'd3, 8'd2, 1'b0, 1'b0, FILL_ONES,
			1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_1BS, 16'd0, 8'd7, 1'b0, 1'b0, FILL_RAND,
			1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_4BS, 16'd10, 8'd7, 1'b0, 1'b0, FILL_SYNC,
			1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::SYNC_BYTE, esp3pd_pkg::SYNC_BYTE, 16'h0055, 8'h00, 1'b0, 1'b0,
			FILL_SYNC, 1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_RPS, 16'h0100, 8'd0, 1'b0, 1'b0, FILL_RAND,
			1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RESPONSE, esp3pd_pkg::RET_CODE_OK, 16'd0, 8'd9, 1'b0, 1'b0,
			FILL_ONES, 1'b0, esp3pd_pkg::RES_NEW},
		'{esp3pd_pkg::TYPE_RADIO, esp3pd_pkg::ORG_4BS, 16'd1, 8'd3, 1'b0, 1'b0, FILL_ONES,
			1'b0, esp3pd_pkg::RES_NEW}
	};

	logic clk = 1'b0;
	logic arst_n;

	esp3pd_rx_if  din_if ();
	esp3pd_res_if dout_if ();

	esp3_packet_deframer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	always #5 clk = ~clk;

	// predictor state
	esp3pd_pkg::phase_t ph = esp3pd_pkg::PH_HUNT;
	logic [16:0] pos = '0;
	logic [16:0] plen = '0;
	logic [7:0]  crc_acc = '0;
	logic [7:0]  hdr [esp3pd_pkg::HDR_LEN];
	logic [7:0]  front [KEEP_FRONT];
	logic [7:0]  tail [KEEP_TAIL];

	tx_byte_t  byte_q [$];
	telegram_t telegram_q [$];
	tx_byte_t  cur_item;
	telegram_t pred, want, seen;
	logic      got;

	int n_errors = 0;
	int n_checked = 0;
	int n_accepted = 0;
	int n_packets = 0;
	int n_pkt_bytes = 0;
	int n_noise = 0;
	int n_in_stalls = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	logic [9:0] rx_cyc = '0;

	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		c = acc ^ b;
		repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ esp3pd_pkg::CRC_POLY) : {c[6:0], 1'b0};
		return c;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, output logic fired,
		output telegram_t t);
		int k;
		fired = 1'b0;
		t = '0;
		case (ph)
		esp3pd_pkg::PH_HUNT: begin
			if (b == esp3pd_pkg::SYNC_BYTE) begin
				pos = '0;
				plen = '0;
				crc_acc = '0;
				for (k = 0; k < esp3pd_pkg::HDR_LEN; k++) hdr[k] = '0;
				for (k = 0; k < KEEP_FRONT; k++) front[k] = '0;
				for (k = 0; k < KEEP_TAIL; k++) tail[k] = '0;
				ph = esp3pd_pkg::PH_HEADER;
			end
		end
		esp3pd_pkg::PH_HEADER: begin
			hdr[pos[1:0]] = b;
			crc_acc = crc8_step(crc_acc, b);
			pos = pos + 17'd1;
			if (pos >= esp3pd_pkg::HDR_LEN) ph = esp3pd_pkg::PH_HCRC;
		end
		esp3pd_pkg::PH_HCRC: begin
			t.kind = hdr[3];
			if (hdr[0] == 8'h00 && hdr[1] == 8'h00 && hdr[2] == 8'h00) begin
				// zero length wins over the header CRC
				fired = 1'b1;
				t.code = esp3pd_pkg::RES_INVALID;
				ph = esp3pd_pkg::PH_HUNT;
			end else if (crc_acc != b) begin
				fired = 1'b1;
				t.code = esp3pd_pkg::RES_BAD_CRC;
				ph = esp3pd_pkg::PH_HUNT;
			end else begin
				plen = {1'b0, hdr[0], hdr[1]} + {9'd0, hdr[2]};
				pos = '0;
				crc_acc = '0;
				ph = esp3pd_pkg::PH_DATA;
			end
		end
		esp3pd_pkg::PH_DATA: begin
			if (pos < KEEP_FRONT) front[pos[3:0]] = b;
			for (k = 0; k < KEEP_TAIL - 1; k++) tail[k] = tail[k+1];
			tail[KEEP_TAIL-1] = b;
			crc_acc = crc8_step(crc_acc, b);
			pos = pos + 17'd1;
			if (pos >= plen) ph = esp3pd_pkg::PH_DCRC;
		end
		esp3pd_pkg::PH_DCRC: begin
			fired = 1'b1;
			ph = esp3pd_pkg::PH_HUNT;
			t.kind = hdr[3];
			if (crc_acc != b) begin
				t.code = esp3pd_pkg::RES_BAD_CRC;
			end else if (hdr[3] == esp3pd_pkg::TYPE_RESPONSE &&
				front[0] != esp3pd_pkg::RET_CODE_OK) begin
				t.code = esp3pd_pkg::RES_INVALID;
			end else begin
				t.code = esp3pd_pkg::RES_NEW;
				t.org = front[0];
				if (hdr[3] == esp3pd_pkg::TYPE_RADIO) begin
					t.subcnt = tail[0];
					t.dest = {tail[4], tail[3], tail[2], tail[1]};
					t.dbm = tail[5];
					if (front[0] == esp3pd_pkg::ORG_RPS || front[0] == esp3pd_pkg::ORG_1BS) begin
						t.payload = {24'd0, front[1]};
						t.sid = {front[5], front[4], front[3], front[2]};
						t.status = front[6];
					end else if (front[0] == esp3pd_pkg::ORG_4BS) begin
						t.payload = {front[1], front[2], front[3], front[4]};
						t.sid = {front[8], front[7], front[6], front[5]};
						t.status = front[9];
					end
				end else if (hdr[3] == esp3pd_pkg::TYPE_RESPONSE) begin
					t.resp = {front[5], front[4], front[3], front[2], front[1], front[0]};
				end
			end
		end
		default: ph = esp3pd_pkg::PH_HUNT;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= MAX_SHOWN) $display("MISMATCH: %s", msg);
	endtask

	task automatic cmp_field(input string name, input logic [47:0] g, input logic [47:0] w);
		if (g !== w)
			report_mismatch($sformatf("telegram %0d %s got %0h want %0h", n_checked, name, g, w));
	endtask

	task automatic push_byte(input logic [7:0] b, input logic typed, input logic [1:0] code,
		input logic [7:0] kind);
		byte_q.push_back('{b, typed, code, kind});
		n_pkt_bytes++;
	endtask

	task automatic push_noise(input int n, input logic allow_sync);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (!allow_sync && b == esp3pd_pkg::SYNC_BYTE) b = b ^ 8'h01;
			byte_q.push_back('{b, 1'b0, esp3pd_pkg::RES_NEW, 8'h00});
			n_noise++;
		end
	endtask

	task automatic push_packet(input logic [7:0] kind, input logic [7:0] org,
		input logic [15:0] dlen, input logic [7:0] olen, input logic bad_h, input logic bad_d,
		input logic [1:0] fill, input logic typed, input logic [1:0] code);
		logic [7:0] hb [esp3pd_pkg::HDR_LEN];
		logic [7:0] crc, b;
		logic       early;
		int         total;
		hb[0] = dlen[15:8];
		hb[1] = dlen[7:0];
		hb[2] = olen;
		hb[3] = kind;
		total = int'(dlen) + int'(olen);
		early = bad_h || total == 0;
		n_packets++;
		crc = '0;
		push_byte(esp3pd_pkg::SYNC_BYTE, 1'b0, esp3pd_pkg::RES_NEW, kind);
		for (int i = 0; i < esp3pd_pkg::HDR_LEN; i++) begin
			push_byte(hb[i], 1'b0, esp3pd_pkg::RES_NEW, kind);
			crc = crc8_step(crc, hb[i]);
		end
		if (bad_h) crc = crc ^ 8'($urandom_range(1, 255));
		push_byte(crc, early && typed, code, kind);
		if (early) return;
		crc = '0;
		for (int i = 0; i < total; i++) begin
			case (fill)
			FILL_ZERO: b = 8'h00;
			FILL_ONES: b = 8'hFF;
			FILL_SYNC: b = esp3pd_pkg::SYNC_BYTE;
			default:   b = 8'($urandom_range(0, 255));
			endcase
			if (i == 0) b = org;
			push_byte(b, 1'b0, esp3pd_pkg::RES_NEW, kind);
			crc = crc8_step(crc, b);
		end
		if (bad_d) crc = crc ^ 8'($urandom_range(1, 255));
		push_byte(crc, typed, code, kind);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		while (byte_q.size() != 0 || din_if.valid || telegram_q.size() != 0) @(negedge clk);
	endtask

	// sender, predictor and result checker share one edge so queue order is fixed
	always @(posedge clk) begin
		if (arst_n) begin
			if (dout_if.valid && dout_if.ready) begin
				seen = '{dout_if.result_code, dout_if.packet_kind, dout_if.radio_org,
					dout_if.payload_word, dout_if.sender_id, dout_if.sender_status,
					dout_if.subtelegram_count, dout_if.destination_id, dout_if.signal_dbm,
					dout_if.response_bytes};
				if (telegram_q.size() == 0) begin
					report_mismatch($sformatf("result word with nothing expected, code %0d kind %0h",
						seen.code, seen.kind));
				end else begin
					want = telegram_q.pop_front();
					cmp_field("result_code", 48'(seen.code), 48'(want.code));
					cmp_field("packet_kind", 48'(seen.kind), 48'(want.kind));
					cmp_field("radio_org", 48'(seen.org), 48'(want.org));
					cmp_field("payload_word", 48'(seen.payload), 48'(want.payload));
					cmp_field("sender_id", 48'(seen.sid), 48'(want.sid));
					cmp_field("sender_status", 48'(seen.status), 48'(want.status));
					cmp_field("subtelegram_count", 48'(seen.subcnt), 48'(want.subcnt));
					cmp_field("destination_id", 48'(seen.dest), 48'(want.dest));
					cmp_field("signal_dbm", 48'(seen.dbm), 48'(want.dbm));
					cmp_field("response_bytes", seen.resp, want.resp);
					n_checked++;
				end
			end
			if (din_if.valid && din_if.ready) begin
				n_accepted++;
				deframe_byte(cur_item.b, got, pred);
				if (got) begin
					if (cur_item.typed) begin
						pred = '0;
						pred.code = cur_item.code;
						pred.kind = cur_item.kind;
					end
					telegram_q.push_back(pred);
				end
			end
			if (din_if.valid && !din_if.ready) n_in_stalls++;
			if (!din_if.valid || din_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					din_if.valid <= 1'b0;
				end else if (byte_q.size() > 0) begin
					cur_item = byte_q.pop_front();
					din_if.valid <= 1'b1;
					din_if.rx_byte <= cur_item.b;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
					end
				end else begin
					din_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: long holds on request, otherwise a pattern set by the top bits of rx_cyc
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 10'd1;
		if (hold_left > 0) begin
			hold_left--;
			dout_if.ready <= 1'b0;
		end else if (hold_reqs != hold_done) begin
			hold_done++;
			hold_left = HOLD_CYCLES - 1;
			dout_if.ready <= 1'b0;
		end else begin
			case (rx_cyc[9:8])
			2'd0: dout_if.ready <= 1'b1;
			2'd1: dout_if.ready <= 1'($urandom_range(0, 1));
			2'd2: dout_if.ready <= (rx_cyc[1:0] == 2'd0);
			default: dout_if.ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_esp3_packet_deframer_unit failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          rand_base;
		int          pick;
		logic [7:0]  r_kind, r_org, r_olen;
		logic [15:0] r_dlen;
		logic [1:0]  r_fill;
		logic        r_bad_h, r_bad_d, mid_done;

		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.rx_byte = 8'h00;
		dout_if.ready = 1'b0;
		mid_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// hunting must drop these
		byte_q.push_back('{8'h00, 1'b0, esp3pd_pkg::RES_NEW, 8'h00});
		byte_q.push_back('{8'hFF, 1'b0, esp3pd_pkg::RES_NEW, 8'h00});
		byte_q.push_back('{8'h54, 1'b0, esp3pd_pkg::RES_NEW, 8'h00});
		byte_q.push_back('{8'hAA, 1'b0, esp3pd_pkg::RES_NEW, 8'h00});
		n_noise += 4;
		for (int i = 0; i < NUM_ROWS; i++)
			push_packet(dir_rows[i].kind, dir_rows[i].org, dir_rows[i].dlen, dir_rows[i].olen,
				dir_rows[i].bad_h, dir_rows[i].bad_d, dir_rows[i].fill, dir_rows[i].typed,
				dir_rows[i].code);
		wait_drain();

		rand_base = n_pkt_bytes;
		hold_reqs++;
		while (n_pkt_bytes - rand_base < TARGET_BYTES) begin
			if (!mid_done && n_pkt_bytes - rand_base >= TARGET_BYTES / 2) begin
				// sender pauses until every telegram is out, then another hold
				mid_done = 1'b1;
				wait_drain();
				hold_reqs++;
			end
			if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 4), 1'b0);
			pick = $urandom_range(0, 99);
			r_fill = FILL_RAND;
			if ($urandom_range(0, 5) == 0) r_fill = 2'($urandom_range(1, 3));
			r_bad_h = ($urandom_range(0, 19) == 0);
			r_bad_d = ($urandom_range(0, 11) == 0);
			if (pick < 50) begin
				case ($urandom_range(0, 2))
				0: r_org = esp3pd_pkg::ORG_RPS;
				1: r_org = esp3pd_pkg::ORG_1BS;
				default: r_org = esp3pd_pkg::ORG_4BS;
				endcase
				r_dlen = (r_org == esp3pd_pkg::ORG_4BS) ? 16'd10 : 16'd7;
				if ($urandom_range(0, 9) == 0) r_dlen = 16'($urandom_range(1, 12));
				r_olen = ($urandom_range(0, 3) != 0) ? 8'd7 : 8'($urandom_range(0, 9));
				push_packet(esp3pd_pkg::TYPE_RADIO, r_org, r_dlen, r_olen, r_bad_h, r_bad_d,
					r_fill, 1'b0, esp3pd_pkg::RES_NEW);
			end else if (pick < 65) begin
				r_org = ($urandom_range(0, 3) != 0) ? esp3pd_pkg::RET_CODE_OK :
					8'($urandom_range(1, 255));
				push_packet(esp3pd_pkg::TYPE_RESPONSE, r_org, 16'($urandom_range(1, 8)),
					8'($urandom_range(0, 2)), r_bad_h, r_bad_d, r_fill, 1'b0,
					esp3pd_pkg::RES_NEW);
			end else if (pick < 78) begin
				r_kind = 8'($urandom_range(0, 255));
				r_org = 8'($urandom_range(0, 255));
				push_packet(r_kind, r_org, 16'($urandom_range(0, 20)), 8'($urandom_range(0, 10)),
					r_bad_h, r_bad_d, r_fill, 1'b0, esp3pd_pkg::RES_NEW);
			end else if (pick < 84) begin
				push_packet(8'($urandom_range(0, 255)), 8'h00, 16'd0, 8'd0, r_bad_h, 1'b0,
					FILL_RAND, 1'b0, esp3pd_pkg::RES_NEW);
			end else if (pick < 92) begin
				// broken frame: the next packet gets swallowed as its body
				push_byte(esp3pd_pkg::SYNC_BYTE, 1'b0, esp3pd_pkg::RES_NEW, 8'h00);
				repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)), 1'b0,
					esp3pd_pkg::RES_NEW, 8'h00);
			end else begin
				push_noise($urandom_range(1, 8), 1'b1);
			end
		end

		wait_drain();
		repeat (DRAIN_TAIL) @(negedge clk);
		if (telegram_q.size() != 0)
			report_mismatch($sformatf("%0d telegrams never came out", telegram_q.size()));
		$display("covered %0d packets plus %0d noise bytes: %0d bytes taken, %0d checked",
			n_packets, n_noise, n_accepted, n_checked);
		$display("input stalled %0d cycles behind %0d long output holds; %0d mismatches",
			n_in_stalls, hold_done, n_errors);
		if (n_errors == 0)
			$display("tb_esp3_packet_deframer_unit passed");
		else
			$display("tb_esp3_packet_deframer_unit failed");
		$finish;
	end

endmodule
